// File: rtl/taie_pkg.sv
// Package for the three-address instruction executor: opcodes, widths and payload types.
// Used by every module of the block; depends on nothing.
package taie_pkg;

  localparam int DataWords    = 128;
  localparam int AddrW        = $clog2(DataWords);
  localparam int ProgramLines = 1024;
  localparam int IndexW       = $clog2(ProgramLines);

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB = 4'd1,  OP_MUL = 4'd2,  OP_DIV = 4'd3,
    OP_AFC  = 4'd4,  OP_COP = 4'd5,  OP_EQU = 4'd6,  OP_NE  = 4'd7,
    OP_SUP  = 4'd8,  OP_INF = 4'd9,  OP_SE  = 4'd10, OP_LE  = 4'd11,
    OP_JMPF = 4'd12, OP_JMP = 4'd13, OP_PRI = 4'd14, OP_UNK = 4'd15
  } opcode_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [6:0]  dest_addr;
    logic [6:0]  src_a_addr;
    logic [6:0]  src_b_addr;
    logic signed [31:0] immediate;
    logic [10:0] jump_line;
  } instr_t;

  typedef struct packed {
    logic [9:0]  next_index;
    logic        halted;
    logic        print_valid;
    logic signed [31:0] print_value;
    logic        unknown_op;
    logic        divide_by_zero;
  } result_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

// File: rtl/three_address_instruction_executor_unit.sv
// Top level of the three-address instruction executor: sequencer, data memory, divider.
// Depends on taie_pkg, taie_data_ram and taie_divider.
//
//   channel   direction  handshake      payload
//   in        input      valid / stall  taie_pkg::instr_t
//   out       output     valid / stall  taie_pkg::result_t
//   cfg       input      valid / ready  program_length, 10 bits
//
// An item passes through read, execute and write back; a multiply adds the S_MUL state,
// and a divide with a nonzero divisor waits in S_DIV on the bit-serial divider.
// Synchronous reset clears the program index, program_length and control state;
// data words are undefined until written. While a result is stalled the next
// item is accepted but waits in the read state until the output register frees.
module three_address_instruction_executor_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  taie_pkg::instr_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output taie_pkg::result_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [9:0]        cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_WAIT} state_t;

  state_t            state;
  taie_pkg::instr_t  ins;
  logic [9:0]        program_length;
  logic [taie_pkg::IndexW:0] pidx;
  logic [31:0]       a_data, b_data;
  logic [31:0]       mul_q;
  logic              wr_en;
  logic [31:0]       wr_data;
  logic              div_done;
  logic [31:0]       div_q;
  taie_pkg::div_req_t div_req;
  taie_pkg::result_t res_next;
  logic [31:0]       alu;
  logic              alu_wr, alu_dz, take_jump, alu_unk, alu_pri;
  logic [taie_pkg::IndexW:0] seq_next, nxt;
  logic [taie_pkg::IndexW-1:0] jump_idx;
  logic              halted_now;
  logic signed [31:0] as_v, bs_v;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  taie_data_ram u_ram (
    .clk       (clk),
    .rd_a_addr (state == S_IDLE ? in_data.src_a_addr : ins.src_a_addr),
    .rd_b_addr (state == S_IDLE ? in_data.src_b_addr :
                (ins.mode == taie_pkg::OP_JMPF || ins.mode == taie_pkg::OP_PRI) ?
                ins.dest_addr : ins.src_b_addr),
    .rd_a_data (a_data),
    .rd_b_data (b_data),
    .wr_en     (wr_en),
    .wr_addr   (ins.dest_addr),
    .wr_data   (wr_data)
  );

  assign div_req.start    = (state == S_EXEC) && (ins.mode == taie_pkg::OP_DIV) &&
                            (b_data != 32'd0) && !halted_now;
  assign div_req.dividend = a_data;
  assign div_req.divisor  = b_data;

  taie_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Operation decode and result for the instruction in S_EXEC.
  assign as_v = a_data;
  assign bs_v = b_data;
  assign halted_now = (pidx > {1'b0, program_length});
  assign jump_idx = ins.jump_line[taie_pkg::IndexW-1:0] - 1'b1;
  assign seq_next = (pidx == (taie_pkg::IndexW+1)'(taie_pkg::ProgramLines))
                    ? pidx : pidx + 1'b1;

  always_comb begin
    alu = 32'd0; alu_wr = 1'b1; alu_dz = 1'b0; take_jump = 1'b0;
    alu_unk = 1'b0; alu_pri = 1'b0;
    case (ins.mode)
      taie_pkg::OP_ADD:  alu = a_data + b_data;
      taie_pkg::OP_SUB:  alu = a_data - b_data;
      taie_pkg::OP_MUL:  alu = 32'd0;
      taie_pkg::OP_DIV:  alu_dz = (b_data == 32'd0);
      taie_pkg::OP_AFC:  alu = ins.immediate;
      taie_pkg::OP_COP:  alu = a_data;
      taie_pkg::OP_EQU:  alu = {31'd0, as_v == bs_v};
      taie_pkg::OP_NE:   alu = {31'd0, as_v != bs_v};
      taie_pkg::OP_SUP:  alu = {31'd0, as_v >  bs_v};
      taie_pkg::OP_INF:  alu = {31'd0, as_v <  bs_v};
      taie_pkg::OP_SE:   alu = {31'd0, as_v >= bs_v};
      taie_pkg::OP_LE:   alu = {31'd0, as_v <= bs_v};
      taie_pkg::OP_JMPF: begin alu_wr = 1'b0; take_jump = (b_data == 32'd0); end
      taie_pkg::OP_JMP:  begin alu_wr = 1'b0; take_jump = 1'b1; end
      taie_pkg::OP_PRI:  begin alu_wr = 1'b0; alu_pri = 1'b1; end
      default:           begin alu_wr = 1'b0; alu_unk = 1'b1; end
    endcase
  end

  assign nxt = take_jump ? {1'b0, jump_idx} : seq_next;

  always_comb begin
    res_next.next_index     = nxt[taie_pkg::IndexW-1:0];
    res_next.halted         = (nxt > {1'b0, program_length});
    res_next.print_valid    = alu_pri;
    res_next.print_value    = alu_pri ? b_data : 32'd0;
    res_next.unknown_op     = alu_unk;
    res_next.divide_by_zero = alu_dz;
  end

  // Sequencer: accept, read, execute, optional multi-cycle unit, write back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pidx           <= '0;
      program_length <= 10'd0;
      out_valid      <= 1'b0;
      wr_en          <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        program_length <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ins   <= in_data;
            state <= S_READ;
          end
        end
        S_READ: begin
          // Wait for a free output register; memory data arrives on entry to S_EXEC.
          if (!out_valid || !out_stall) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (halted_now) begin
            out_data  <= '{next_index: pidx[taie_pkg::IndexW-1:0], halted: 1'b1,
                           print_valid: 1'b0, print_value: 32'd0,
                           unknown_op: 1'b0, divide_by_zero: 1'b0};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (ins.mode == taie_pkg::OP_MUL) begin
            mul_q    <= a_data * b_data;
            out_data <= res_next;
            pidx     <= nxt;
            state    <= S_MUL;
          end else if (div_req.start) begin
            out_data <= res_next;
            pidx     <= nxt;
            state    <= S_DIV;
          end else begin
            wr_en     <= alu_wr;
            wr_data   <= alu;
            out_data  <= res_next;
            out_valid <= 1'b1;
            pidx      <= nxt;
            state     <= S_IDLE;
          end
        end
        S_MUL: begin
          wr_en     <= 1'b1;
          wr_data   <= mul_q;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            wr_en     <= 1'b1;
            wr_data   <= div_q;
            out_valid <= 1'b1;
            state     <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/taie_data_ram.sv
// Data memory of the executor: two synchronous read ports and one write port.
// Depends on taie_pkg for the depth and address width.
module taie_data_ram (
  input  logic                        clk,
  input  logic [taie_pkg::AddrW-1:0]  rd_a_addr,
  input  logic [taie_pkg::AddrW-1:0]  rd_b_addr,
  output logic [31:0]                 rd_a_data,
  output logic [31:0]                 rd_b_data,
  input  logic                        wr_en,
  input  logic [taie_pkg::AddrW-1:0]  wr_addr,
  input  logic [31:0]                 wr_data
);

  logic [31:0] mem [taie_pkg::DataWords];

  // One write and two registered reads per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// File: rtl/taie_divider.sv
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on taie_pkg for the request struct.
module taie_divider (
  input  logic               clk,
  input  logic               rst,
  input  taie_pkg::div_req_t req,
  output logic               done,
  output logic [31:0]        quotient
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [5:0]  count;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};

  // Shift-subtract loop; the sign is applied combinationally at the quotient output.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= 6'd0;
        rem   <= 32'd0;
        quo   <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
        dvs   <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
        neg   <= req.dividend[31] ^ req.divisor[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        count <= count + 6'd1;
        if (count == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? (32'd0 - quo) : quo;

endmodule

// File: rtl/taie_checker.sv
// Port-level checker for the executor, bound to the top level.
// Depends on taie_pkg for the payload types.
module taie_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input taie_pkg::result_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A transfer in cannot produce a result in the very next cycle.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result too early");

  // Print value is zero unless a print happened.
  a_print: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.print_valid |-> out_data.print_value == 32'd0)
    else $error("print value without print");

  // Only one flag of print, unknown and divide by zero at a time.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({out_data.print_valid, out_data.unknown_op,
                            out_data.divide_by_zero}))
    else $error("conflicting flags");

endmodule

bind three_address_instruction_executor_unit taie_checker u_taie_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
